/* rtl/core/slpbm_pkg.sv */
// Shared types and constants for the serial-loaded program bank mapper.
package slpbm_pkg;

    // One CPU bus access.
    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_in_item;

    // One mapped access.
    typedef struct packed {
        logic [1:0]  target;
        logic [18:0] mem_addr;
        logic [7:0]  write_data;
        logic [1:0]  mirroring;
    } t_out_item;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        TGT_NONE      = 2'd0,
        TGT_RAM_READ  = 2'd1,
        TGT_RAM_WRITE = 2'd2,
        TGT_ROM_READ  = 2'd3
    } t_target;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ROM_BANK_COUNT = 2'd0,
        CFG_RAM_PRESENT    = 2'd1,
        CFG_SPARE2         = 2'd2,
        CFG_SPARE3         = 2'd3
    } t_cfg_index;

    // Register chosen by address bits 14:13 on the fifth loader write.
    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR0    = 2'd1,
        SEL_CHR1    = 2'd2,
        SEL_PRG     = 2'd3
    } t_reg_sel;

    // PRG bank mode, control bits 3:2.
    typedef enum logic [1:0] {
        MODE_32K_A    = 2'd0,
        MODE_32K_B    = 2'd1,
        MODE_FIX_LOW  = 2'd2,
        MODE_FIX_HIGH = 2'd3
    } t_prg_mode;

    localparam logic [4:0] LOADER_MARK    = 5'h10;
    localparam logic [4:0] FIX_HIGH_BITS  = 5'h0C;
    localparam logic [5:0] RESET_BANK_CNT = 6'd16;
    localparam logic [5:0] SMALL_BANK_CNT = 6'd16;

    // Bank windows as seen by reads, plus mirroring after the current access.
    typedef struct packed {
        logic [4:0] low_bank;
        logic [4:0] high_bank;
        logic [1:0] mirror_next;
    } t_bank_view;

endpackage

/* rtl/core/serial_loaded_prg_bank_mapper.sv */
// Top level: CPU bus access decode, program bank mapping and result register.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+-----------------------------
//  input    | i_in_valid  | o_in_ready  | i_in  (op, addr, data)
//  result   | o_out_valid | i_out_ready | o_out (target, mem_addr, ...)
//  config   | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One access per cycle while the result is not stalled; the result shows in the cycle after
// its transfer, set by the single decode and bank mux stage in front of the result register.
// Reset (synchronous, active low) loads the loader marker, fix-high mode,
// 16 banks and work RAM present, and empties the result register.
// A stalled result blocks input only while it is held; config is always taken.
module serial_loaded_prg_bank_mapper (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  slpbm_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output slpbm_pkg::t_out_item o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [5:0]           i_cfg_data
);
    import slpbm_pkg::*;

    logic       in_xfer;
    logic       cfg_xfer;
    logic       is_ram;
    logic       is_rom;
    logic       reg_load;
    logic [4:0] rd_bank;
    t_bank_view view;
    t_out_item  n_out;
    t_out_item  r_out;
    logic       r_out_valid;
    logic       r_ram_present;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    assign is_rom   = i_in.addr[15];
    assign is_ram   = (i_in.addr[15:13] == 3'b011);
    assign reg_load = in_xfer && is_rom && (t_op'(i_in.op) == OP_WRITE);

    slpbm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (reg_load),
        .i_reg_sel  (i_in.addr[14:13]),
        .i_data     (i_in.data),
        .i_count_we (cfg_xfer && t_cfg_index'(i_cfg_index) == CFG_ROM_BANK_COUNT),
        .i_count    (i_cfg_data),
        .o_view     (view)
    );

    // 0x8000-0xBFFF reads the low window, 0xC000 and up the high window.
    assign rd_bank = i_in.addr[14] ? view.high_bank : view.low_bank;

    always_comb begin
        n_out            = '0;
        n_out.mirroring  = view.mirror_next;
        if (is_ram && r_ram_present) begin
            n_out.mem_addr = {6'd0, i_in.addr[12:0]};
            if (t_op'(i_in.op) == OP_WRITE) begin
                n_out.target     = TGT_RAM_WRITE;
                n_out.write_data = i_in.data;
            end else begin
                n_out.target = TGT_RAM_READ;
            end
        end else if (is_rom && t_op'(i_in.op) == OP_READ) begin
            n_out.target   = TGT_ROM_READ;
            n_out.mem_addr = {rd_bank, i_in.addr[13:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_ram_present <= 1'b1;
        end else begin
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_xfer && t_cfg_index'(i_cfg_index) == CFG_RAM_PRESENT) begin
                r_ram_present <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result register not empty after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result is stalled");

    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.target != TGT_RAM_WRITE) |-> (o_out.write_data == 8'd0))
        else $error("write data set on non-write result");

    a_unmapped_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.target == TGT_NONE) |-> (o_out.mem_addr == 19'd0))
        else $error("address set on unmapped result");
`endif

endmodule

/* rtl/core/slpbm_regs.sv */
// Serial loader, mapper registers and bank window selection.
module slpbm_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [1:0]             i_reg_sel,
    input  logic [7:0]             i_data,
    input  logic                   i_count_we,
    input  logic [5:0]             i_count,
    output slpbm_pkg::t_bank_view  o_view
);
    import slpbm_pkg::*;

    logic [4:0] r_shift, n_shift;
    logic [4:0] r_control, n_control;
    logic [4:0] r_chr0, n_chr0;
    logic [4:0] r_chr1, n_chr1;
    logic [4:0] r_prg, n_prg;
    logic [5:0] r_count, n_count;

    logic [4:0] word;
    logic [4:0] sel;
    logic [4:0] last;

    assign word = {i_data[0], r_shift[4:1]};

    always_comb begin
        n_shift   = r_shift;
        n_control = r_control;
        n_chr0    = r_chr0;
        n_chr1    = r_chr1;
        n_prg     = r_prg;
        n_count   = i_count_we ? i_count : r_count;
        if (i_load) begin
            priority if (i_data[7]) begin
                // loader reset: drop partial word, force fix-high mode
                n_shift   = LOADER_MARK;
                n_control = r_control | FIX_HIGH_BITS;
            end else if (!r_shift[0]) begin
                n_shift = word;
            end else begin
                n_shift = LOADER_MARK;
                unique case (t_reg_sel'(i_reg_sel))
                    SEL_CONTROL: n_control = word;
                    SEL_CHR0:    n_chr0    = word;
                    SEL_CHR1:    n_chr1    = word;
                    SEL_PRG:     n_prg     = word;
                    default:     n_prg     = word;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= LOADER_MARK;
            r_control <= FIX_HIGH_BITS;
            r_chr0    <= '0;
            r_chr1    <= '0;
            r_prg     <= '0;
            r_count   <= RESET_BANK_CNT;
        end else begin
            r_shift   <= n_shift;
            r_control <= n_control;
            r_chr0    <= n_chr0;
            r_chr1    <= n_chr1;
            r_prg     <= n_prg;
            r_count   <= n_count;
        end
    end

    // Windows follow the current registers; CHR1 is kept but unused here.
    assign sel  = {(r_count > SMALL_BANK_CNT) & r_chr0[4], r_prg[3:0]};
    assign last = 5'(r_count - 6'd1);

    always_comb begin
        o_view.mirror_next = n_control[1:0];
        unique case (t_prg_mode'(r_control[3:2]))
            MODE_32K_A, MODE_32K_B: begin
                o_view.low_bank  = {sel[4:1], 1'b0};
                o_view.high_bank = {sel[4:1], 1'b1};
            end
            MODE_FIX_LOW: begin
                o_view.low_bank  = '0;
                o_view.high_bank = sel;
            end
            MODE_FIX_HIGH: begin
                o_view.low_bank  = sel;
                o_view.high_bank = last;
            end
            default: begin
                o_view.low_bank  = sel;
                o_view.high_bank = last;
            end
        endcase
    end

    logic unused_chr1;
    assign unused_chr1 = ^r_chr1;

endmodule
